// ===== rtl/sha256md_pkg.sv =====
// Shared types, constants and functions for the SHA-256 digest block.
// Holds the round constants, the initial hash value and the sigma functions.
// No dependencies.
package sha256md_pkg;

  typedef logic [7:0][31:0] hash_t;

  // Per-cycle control from the sequencer to the buffer and round unit
  typedef struct packed {
    logic       push;       // a byte enters the block buffer
    logic [7:0] push_byte;
    logic       word_done;  // the pushed byte completes a 32-bit word
    logic       load;       // copy the chaining value into the working variables
    logic       round_en;   // run one compression round
    logic       mix;        // schedule word comes from the expansion, not the buffer
  } ctl_t;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenFill   = 6'd56;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LastFill  = 6'd63;

  // Element 0 is word a / H0
  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== rtl/sha256md_sched.sv =====
// Block buffer and message schedule: a 16-word shift window that collects
// bytes into words and then rolls the schedule expansion one word per round.
// Depends on sha256md_pkg.
module sha256md_sched
  import sha256md_pkg::*;
(
  input  logic        clk_i,
  input  ctl_t        ctl_i,
  output logic [31:0] w_o
);

  logic [23:0]       part_q;
  logic [15:0][31:0] win_q;
  logic [31:0]       word_in;

  assign word_in = {part_q, ctl_i.push_byte};

  // Window holds W[t-16] .. W[t-1] with the oldest at element 0
  always_comb begin
    if (ctl_i.mix) begin
      w_o = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
    end else begin
      w_o = win_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      part_q <= word_in[23:0];
      if (ctl_i.word_done) begin
        win_q <= {word_in, win_q[15:1]};
      end
    end else if (ctl_i.round_en) begin
      win_q <= {w_o, win_q[15:1]};
    end
  end

endmodule

// ===== rtl/sha256md_round.sv =====
// Compression round unit: the eight working variables and one SHA-256 round,
// reused for all 64 rounds of a block.
// Depends on sha256md_pkg.
module sha256md_round
  import sha256md_pkg::*;
(
  input  logic        clk_i,
  input  ctl_t        ctl_i,
  input  hash_t       cv_i,
  input  logic [31:0] k_i,
  input  logic [31:0] w_i,
  output hash_t       wv_o
);

  hash_t       wv_q;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
  assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
  assign t1  = wv_q[7] + big_sigma1(wv_q[4]) + ch + k_i + w_i;
  assign t2  = big_sigma0(wv_q[0]) + maj;
  assign wv_o = wv_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      wv_q <= cv_i;
    end else if (ctl_i.round_en) begin
      wv_q <= {wv_q[6:4], wv_q[3] + t1, wv_q[2:0], t1 + t2};
    end
  end

endmodule

// ===== rtl/sha256md_top_note.sv =====
// Byte-push helper: decides whether a byte closes a
// 32-bit word or the 64-byte block. Depends on sha256md_pkg.
module sha256md_push
  import sha256md_pkg::*;
(
  input  logic [5:0] fill_i,
  input  logic       push_i,
  output logic       word_done_o,
  output logic       block_full_o
);

  assign word_done_o  = push_i && (fill_i[1:0] == 2'b11);
  assign block_full_o = push_i && (fill_i == LastFill);

endmodule

// ===== rtl/sha256_message_digest.sv =====
// SHA-256 over a byte stream. An input item that completes a 64-byte block
// starts a compression by a single round unit at one round per cycle, and
// no new item is taken until the result is folded into the chaining value.
// An end-of-message item starts padding, pushed one byte per cycle through the
// same buffer path outside compressions (one or two), after which the eight
// digest words are offered one per cycle while out_stall_i is low, word 0 first.
// Depends on sha256md_pkg, sha256md_push, sha256md_sched and sha256md_round.
module sha256_message_digest
  import sha256md_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD80, S_ZERO, S_LEN, S_COMP, S_FINAL, S_OUT
  } state_e;

  state_e      state_q, state_d;
  state_e      ret_q, ret_d;
  state_e      tgt;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] count_q, count_d;
  logic [63:0] len_q, len_d;
  logic [2:0]  lencnt_q, lencnt_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  idx_q, idx_d;
  hash_t       cv_q, cv_d;
  hash_t       wv;
  logic [31:0] w;
  logic        in_accept;
  logic        out_accept;
  logic        push;
  logic [7:0]  push_byte;
  logic        word_done;
  logic        block_full;
  ctl_t        ctl;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_accept  = out_valid_o && !out_stall_i;

  assign digest_word_o = cv_q[0];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

  sha256md_push u_push (
    .fill_i       (fill_q),
    .push_i       (push),
    .word_done_o  (word_done),
    .block_full_o (block_full)
  );

  always_comb begin
    ctl.push      = push;
    ctl.push_byte = push_byte;
    ctl.word_done = word_done;
    ctl.load      = block_full;
    ctl.round_en  = (state_q == S_COMP);
    ctl.mix       = (round_q[5:4] != 2'b00);
  end

  sha256md_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .w_o   (w)
  );

  sha256md_round u_round (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .cv_i  (cv_q),
    .k_i   (RoundK[round_q]),
    .w_i   (w),
    .wv_o  (wv)
  );

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    fill_d    = fill_q;
    count_d   = count_q;
    len_d     = len_q;
    lencnt_d  = lencnt_q;
    round_d   = round_q;
    idx_d     = idx_q;
    cv_d      = cv_q;
    push      = 1'b0;
    push_byte = 8'h00;
    tgt       = state_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          push      = byte_present_i;
          push_byte = data_byte_i;
          tgt       = end_of_message_i ? S_PAD80 : S_IDLE;
          state_d   = tgt;
          if (byte_present_i) begin
            count_d = count_q + 61'd1;
          end
        end
      end
      S_PAD80: begin
        push      = 1'b1;
        push_byte = PadByte;
        tgt       = S_ZERO;
        state_d   = tgt;
      end
      S_ZERO: begin
        if (fill_q == LenFill) begin
          len_d   = {count_q, 3'b000};
          state_d = S_LEN;
        end else begin
          push    = 1'b1;
          tgt     = S_ZERO;
          state_d = tgt;
        end
      end
      S_LEN: begin
        push      = 1'b1;
        push_byte = len_q[63:56];
        len_d     = {len_q[55:0], 8'h00};
        lencnt_d  = lencnt_q + 3'd1;
        tgt       = (lencnt_q == 3'd7) ? S_OUT : S_LEN;
        state_d   = tgt;
      end
      S_COMP: begin
        round_d = round_q + 6'd1;
        if (round_q == LastRound) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          cv_d[i] = cv_q[i] + wv[i];
        end
        state_d = ret_q;
      end
      S_OUT: begin
        if (out_accept) begin
          idx_d = idx_q + 3'd1;
          cv_d  = {cv_q[7], cv_q[7:1]};
          if (last_word_o) begin
            // start over for the next message
            cv_d    = InitHash;
            count_d = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push) begin
      fill_d = fill_q + 6'd1;
    end
    // a full block runs a compression, then carries on where the push left off
    if (block_full) begin
      ret_d   = tgt;
      round_d = '0;
      state_d = S_COMP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      fill_q   <= '0;
      count_q  <= '0;
      lencnt_q <= '0;
      round_q  <= '0;
      idx_q    <= '0;
      cv_q     <= InitHash;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      fill_q   <= fill_d;
      count_q  <= count_d;
      lencnt_q <= lencnt_d;
      round_q  <= round_d;
      idx_q    <= idx_d;
      cv_q     <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

endmodule
